// ----- src/lbdd_pkg.sv -----
package lbdd_pkg;

    localparam int unsigned SAMPLE_BITS = 10;
    localparam int unsigned SETTLE_BITS = 4;
    localparam int unsigned CMP_BITS    = 16;

    localparam logic [SETTLE_BITS-1:0] SETTLE_RESET = SETTLE_BITS'(1);

    localparam logic CH_MEDIA = 1'b0;
    localparam logic CH_TURN  = 1'b1;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;

    localparam logic [2:0] BTN_NONE  = 3'd0;
    localparam logic [2:0] CLS_ERROR = 3'd7;

    // upper band bounds, inclusive, lowest band first
    localparam logic [CMP_BITS-1:0] MEDIA_BOUND [8] =
        '{16'd12, 16'd36, 16'd64, 16'd103, 16'd162, 16'd257, 16'd427, 16'd781};
    localparam logic [2:0] MEDIA_CLASS [8] =
        '{CLS_ERROR, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, BTN_NONE};
    localparam logic [CMP_BITS-1:0] TURN_BOUND [4] =
        '{16'd22, 16'd87, 16'd223, 16'd670};
    localparam logic [2:0] TURN_CLASS [4] =
        '{CLS_ERROR, 3'd1, 3'd2, BTN_NONE};

    typedef struct packed {
        logic                   channel;
        logic [SAMPLE_BITS-1:0] adc_sample;
    } sample_item_t;

    typedef struct packed {
        logic       out_channel;
        logic [1:0] event_kind;
        logic [2:0] button_code;
        logic       sample_invalid;
    } result_item_t;

    typedef struct packed {
        logic [2:0] cls;
        logic       bad;
    } class_t;

endpackage

// ----- src/lbdd_classify.sv -----
module lbdd_classify
(
    input  lbdd_pkg::sample_item_t item,
    output lbdd_pkg::class_t       result
);

    logic [lbdd_pkg::CMP_BITS-1:0] value;
    logic [2:0]                    media_cls;
    logic [2:0]                    turn_cls;
    logic [2:0]                    raw_cls;

    assign value = lbdd_pkg::CMP_BITS'(item.adc_sample);

    // scan from the top band down so the lowest matching band wins
    always_comb
    begin
        media_cls = lbdd_pkg::CLS_ERROR;
        for (int i = 7; i >= 0; i--)
        begin
            if (value <= lbdd_pkg::MEDIA_BOUND[i])
            begin
                media_cls = lbdd_pkg::MEDIA_CLASS[i];
            end
        end
    end

    always_comb
    begin
        turn_cls = lbdd_pkg::CLS_ERROR;
        for (int i = 3; i >= 0; i--)
        begin
            if (value <= lbdd_pkg::TURN_BOUND[i])
            begin
                turn_cls = lbdd_pkg::TURN_CLASS[i];
            end
        end
    end

    assign raw_cls    = (item.channel == lbdd_pkg::CH_TURN) ? turn_cls : media_cls;
    assign result.bad = (raw_cls == lbdd_pkg::CLS_ERROR);
    assign result.cls = result.bad ? lbdd_pkg::BTN_NONE : raw_cls;

endmodule

// ----- src/lbdd_debounce.sv -----
module lbdd_debounce
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             update,
    input  logic                             channel,
    input  logic [2:0]                       cls,
    input  logic [lbdd_pkg::SETTLE_BITS-1:0] settle_count,
    output logic [1:0]                       event_kind,
    output logic [2:0]                       button_code
);

    logic [2:0]                       media_committed_reg;
    logic [2:0]                       media_committed_next;
    logic [1:0]                       turn_committed_reg;
    logic [1:0]                       turn_committed_next;
    logic [lbdd_pkg::SETTLE_BITS-1:0] media_left_reg;
    logic [lbdd_pkg::SETTLE_BITS-1:0] media_left_next;
    logic [lbdd_pkg::SETTLE_BITS-1:0] turn_left_reg;
    logic [lbdd_pkg::SETTLE_BITS-1:0] turn_left_next;

    logic [2:0]                       committed;
    logic [lbdd_pkg::SETTLE_BITS-1:0] left;
    logic [lbdd_pkg::SETTLE_BITS-1:0] left_new;
    logic [lbdd_pkg::SETTLE_BITS-1:0] load;
    logic [lbdd_pkg::SETTLE_BITS-1:0] left_dec;
    logic                             commit;

    assign committed = (channel == lbdd_pkg::CH_TURN) ? {1'b0, turn_committed_reg}
                                                      : media_committed_reg;
    assign left      = (channel == lbdd_pkg::CH_TURN) ? turn_left_reg : media_left_reg;
    // a zero setting still has to allow a commit
    assign load      = (settle_count == '0) ? lbdd_pkg::SETTLE_BITS'(1) : settle_count;
    assign left_dec  = left - lbdd_pkg::SETTLE_BITS'(1);

    always_comb
    begin
        commit      = 1'b0;
        event_kind  = lbdd_pkg::EV_NONE;
        button_code = committed;
        priority if (cls == committed)
        begin
            left_new = '0;
        end
        else if (left == '0)
        begin
            left_new = load;
        end
        else
        begin
            left_new = left_dec;
            if (left_dec == '0)
            begin
                commit      = 1'b1;
                button_code = cls;
                event_kind  = (cls != lbdd_pkg::BTN_NONE) ? lbdd_pkg::EV_PRESS
                                                          : lbdd_pkg::EV_RELEASE;
            end
        end
    end

    always_comb
    begin
        media_committed_next = media_committed_reg;
        turn_committed_next  = turn_committed_reg;
        media_left_next      = media_left_reg;
        turn_left_next       = turn_left_reg;
        if (update)
        begin
            if (channel == lbdd_pkg::CH_TURN)
            begin
                turn_left_next = left_new;
                if (commit)
                begin
                    turn_committed_next = cls[1:0];
                end
            end
            else
            begin
                media_left_next = left_new;
                if (commit)
                begin
                    media_committed_next = cls;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            media_committed_reg <= lbdd_pkg::BTN_NONE;
            turn_committed_reg  <= '0;
            media_left_reg      <= '0;
            turn_left_reg       <= '0;
        end
        else
        begin
            media_committed_reg <= media_committed_next;
            turn_committed_reg  <= turn_committed_next;
            media_left_reg      <= media_left_next;
            turn_left_reg       <= turn_left_next;
        end
    end

    a_media_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        media_committed_reg != lbdd_pkg::CLS_ERROR)
        else $error("media committed button holds the error class");

    a_turn_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        turn_committed_reg != 2'd3)
        else $error("turn committed button out of range");

    a_press_code: assert property (@(posedge clk) disable iff (!rst_n)
        update && (event_kind == lbdd_pkg::EV_PRESS) |-> button_code != lbdd_pkg::BTN_NONE)
        else $error("press event reports no button");

    a_commit_clears_media: assert property (@(posedge clk) disable iff (!rst_n)
        update && commit && (channel == lbdd_pkg::CH_MEDIA) |=>
            media_left_reg == '0 && media_committed_reg == $past(cls))
        else $error("media commit did not clear counter or store button");

    a_commit_clears_turn: assert property (@(posedge clk) disable iff (!rst_n)
        update && commit && (channel == lbdd_pkg::CH_TURN) |=>
            turn_left_reg == '0 && {1'b0, turn_committed_reg} == $past(cls))
        else $error("turn commit did not clear counter or store button");

endmodule

// ----- src/ladder_button_decode_debounce.sv -----
// Resistor ladder keypad decoder with per-channel debounce. Each transfer on
// the sample channel carries a converter reading and a ladder tag (0 media,
// 1 turn) and yields exactly one result transfer: the channel, a press or
// release event (or none), the button committed after this sample, and a flag
// for readings outside every valid band (treated as no button). A new button
// is committed once 1 + settle_count consecutive samples of its channel differ
// from the committed button, taking the class of the last of them (a setting
// of 0 acts as 1). One sample is taken per clock while the output is not
// stalled; each one is held in the input register and then passes through the
// band compare and counter update into the result register once that register
// is empty or its result is being taken. The settle count register is written
// through the cfg channel only while no sample is in flight, a rule for the user
// that the block itself does not enforce; it resets to 1.
module ladder_button_decode_debounce
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  lbdd_pkg::sample_item_t           sample,
    output logic                             result_valid,
    input  logic                             result_ready,
    output lbdd_pkg::result_item_t           result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lbdd_pkg::SETTLE_BITS-1:0] cfg_data
);

    logic                             s1_valid_reg;
    logic                             s1_valid_next;
    lbdd_pkg::sample_item_t           s1_item_reg;
    logic                             res_valid_reg;
    logic                             res_valid_next;
    lbdd_pkg::result_item_t           res_item_reg;
    lbdd_pkg::result_item_t           res_item_next;
    logic [lbdd_pkg::SETTLE_BITS-1:0] settle_count_reg;
    logic [lbdd_pkg::SETTLE_BITS-1:0] settle_count_next;

    logic                             advance;
    logic                             sample_xfer;
    lbdd_pkg::class_t                 cls;
    logic [1:0]                       event_kind;
    logic [2:0]                       button_code;

    assign advance      = s1_valid_reg && (!res_valid_reg || result_ready);
    assign sample_ready = !s1_valid_reg || advance;
    assign sample_xfer  = sample_valid && sample_ready;
    assign cfg_ready    = 1'b1;

    lbdd_classify u_classify
    (
        .item   (s1_item_reg),
        .result (cls)
    );

    lbdd_debounce u_debounce
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .update       (advance),
        .channel      (s1_item_reg.channel),
        .cls          (cls.cls),
        .settle_count (settle_count_reg),
        .event_kind   (event_kind),
        .button_code  (button_code)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        res_valid_next = res_valid_reg;
        if (sample_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        res_item_next.out_channel    = s1_item_reg.channel;
        res_item_next.event_kind     = event_kind;
        res_item_next.button_code    = button_code;
        res_item_next.sample_invalid = cls.bad;
        settle_count_next = (cfg_valid && cfg_ready) ? cfg_data : settle_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
            settle_count_reg <= lbdd_pkg::SETTLE_RESET;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            res_valid_reg    <= res_valid_next;
            settle_count_reg <= settle_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            s1_item_reg <= sample;
        end
        if (advance)
        begin
            res_item_reg <= res_item_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_item_reg;

endmodule

// ----- test/ladder_button_decode_debounce_tb.sv -----
module ladder_button_decode_debounce_tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int BATCH_ITEMS = 65;

    // idle patterns: percent of cycles the sender idles / the receiver stalls
    localparam int MODE_COUNT = 4;
    localparam int SENDER_IDLE_PCT [MODE_COUNT] = '{0, 78, 0, 23};
    localparam int RECEIVER_STALL_PCT [MODE_COUNT] = '{0, 0, 78, 23};

    localparam logic [2:0] BTN_VOLDOWN = 3'd1;
    localparam logic [2:0] BTN_VOLUP   = 3'd2;
    localparam logic [2:0] BTN_SOURCE  = 3'd3;
    localparam logic [2:0] BTN_NEXT    = 3'd4;
    localparam logic [2:0] BTN_PREV    = 3'd5;
    localparam logic [2:0] BTN_UP      = 3'd6;
    localparam logic [2:0] BTN_RIGHT   = 3'd1;
    localparam logic [2:0] BTN_LEFT    = 3'd2;

    // ladder bands: inclusive top of each band, lowest first, and its class
    localparam int MEDIA_BANDS = 9;
    localparam int TURN_BANDS  = 5;
    localparam int MEDIA_TOP [MEDIA_BANDS] = '{12, 36, 64, 103, 162, 257, 427, 781, 1023};
    localparam logic [2:0] MEDIA_BAND_CLASS [MEDIA_BANDS] = '{lbdd_pkg::CLS_ERROR,
        BTN_VOLDOWN, BTN_VOLUP, BTN_SOURCE, BTN_NEXT, BTN_PREV, BTN_UP,
        lbdd_pkg::BTN_NONE, lbdd_pkg::CLS_ERROR};
    localparam int TURN_TOP [TURN_BANDS] = '{22, 87, 223, 670, 1023};
    localparam logic [2:0] TURN_BAND_CLASS [TURN_BANDS] = '{lbdd_pkg::CLS_ERROR,
        BTN_RIGHT, BTN_LEFT, lbdd_pkg::BTN_NONE, lbdd_pkg::CLS_ERROR};

    localparam int DIRECTED_ITEMS = 28;
    localparam logic DIRECTED_CH [DIRECTED_ITEMS] = '{
        lbdd_pkg::CH_MEDIA, lbdd_pkg::CH_MEDIA, lbdd_pkg::CH_MEDIA, lbdd_pkg::CH_MEDIA,
        lbdd_pkg::CH_MEDIA, lbdd_pkg::CH_MEDIA, lbdd_pkg::CH_MEDIA, lbdd_pkg::CH_MEDIA,
        lbdd_pkg::CH_MEDIA, lbdd_pkg::CH_MEDIA, lbdd_pkg::CH_MEDIA, lbdd_pkg::CH_MEDIA,
        lbdd_pkg::CH_MEDIA, lbdd_pkg::CH_MEDIA, lbdd_pkg::CH_MEDIA, lbdd_pkg::CH_MEDIA,
        lbdd_pkg::CH_MEDIA, lbdd_pkg::CH_MEDIA, lbdd_pkg::CH_MEDIA,
        lbdd_pkg::CH_TURN, lbdd_pkg::CH_TURN, lbdd_pkg::CH_TURN, lbdd_pkg::CH_TURN,
        lbdd_pkg::CH_TURN, lbdd_pkg::CH_TURN, lbdd_pkg::CH_TURN, lbdd_pkg::CH_TURN,
        lbdd_pkg::CH_TURN};
    // walks every band edge; pairs commit at the reset settle count of 1
    localparam int DIRECTED_VALUE [DIRECTED_ITEMS] = '{
        0, 12, 13, 13, 36, 37, 64, 65, 103, 104, 162, 163, 257, 258, 427, 428, 781,
        782, 1023,
        22, 23, 87, 88, 223, 224, 670, 671, 1023};

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             sample_valid = 1'b0;
    logic                             sample_ready;
    lbdd_pkg::sample_item_t           sample = '0;
    logic                             result_valid;
    logic                             result_ready = 1'b0;
    lbdd_pkg::result_item_t           result;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [lbdd_pkg::SETTLE_BITS-1:0] cfg_data = '0;

    lbdd_pkg::sample_item_t           adc_samples_q [$];
    lbdd_pkg::result_item_t           predicted_events [$];
    logic                             sample_taken = 1'b0;
    int                               sender_idle_pct = 0;
    int                               receiver_stall_pct = 0;
    int                               error_count = 0;
    int                               cycle_count = 0;

    // predictor state
    logic [lbdd_pkg::SETTLE_BITS-1:0] settle_cfg = lbdd_pkg::SETTLE_RESET;
    logic [2:0]                       committed_btn [2] =
        '{lbdd_pkg::BTN_NONE, lbdd_pkg::BTN_NONE};
    logic [lbdd_pkg::SETTLE_BITS-1:0] settle_left [2] = '{'0, '0};

    ladder_button_decode_debounce dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int band_count(logic ch);
        return (ch == lbdd_pkg::CH_MEDIA) ? MEDIA_BANDS : TURN_BANDS;
    endfunction

    function automatic int band_top(logic ch, int band);
        return (ch == lbdd_pkg::CH_MEDIA) ? MEDIA_TOP[band] : TURN_TOP[band];
    endfunction

    function automatic logic [2:0] ladder_class(logic ch,
                                                logic [lbdd_pkg::SAMPLE_BITS-1:0] v);
        int band;
        band = 0;
        while (band < band_count(ch) - 1 && int'(v) > band_top(ch, band))
            band++;
        return (ch == lbdd_pkg::CH_MEDIA) ? MEDIA_BAND_CLASS[band] : TURN_BAND_CLASS[band];
    endfunction

    // advances the per-channel debounce and returns the result of this sample
    function automatic lbdd_pkg::result_item_t debounce_predict(lbdd_pkg::sample_item_t s);
        lbdd_pkg::result_item_t           r;
        logic [2:0]                       cls;
        logic [lbdd_pkg::SETTLE_BITS-1:0] load;
        int                               ch;
        ch = int'(s.channel);
        cls = ladder_class(s.channel, s.adc_sample);
        r.sample_invalid = (cls == lbdd_pkg::CLS_ERROR);
        if (cls == lbdd_pkg::CLS_ERROR)
            cls = lbdd_pkg::BTN_NONE;
        load = (settle_cfg == '0) ? lbdd_pkg::SETTLE_BITS'(1) : settle_cfg;
        r.event_kind = lbdd_pkg::EV_NONE;
        if (cls == committed_btn[ch])
        begin
            settle_left[ch] = '0;
        end
        else if (settle_left[ch] == '0)
        begin
            settle_left[ch] = load;
        end
        else
        begin
            settle_left[ch] = settle_left[ch] - 1'b1;
            if (settle_left[ch] == '0)
            begin
                committed_btn[ch] = cls;
                r.event_kind = (cls != lbdd_pkg::BTN_NONE) ? lbdd_pkg::EV_PRESS
                                                           : lbdd_pkg::EV_RELEASE;
            end
        end
        r.out_channel = s.channel;
        r.button_code = committed_btn[ch];
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // driver: new transfer offered only once the previous one is gone
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            result_ready <= ($urandom_range(99) >= receiver_stall_pct);
            if (!sample_valid || sample_taken)
            begin
                if (adc_samples_q.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    sample       <= adc_samples_q.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        lbdd_pkg::result_item_t want;
        if (rst_n)
        begin
            sample_taken = sample_valid && sample_ready;
            if (sample_taken)
                predicted_events.push_back(debounce_predict(sample));
            if (result_valid && result_ready)
            begin
                if (predicted_events.size() == 0)
                begin
                    report_mismatch("result transfer with nothing predicted");
                end
                else
                begin
                    want = predicted_events.pop_front();
                    check_field("out_channel", 4'(result.out_channel), 4'(want.out_channel));
                    check_field("event_kind", 4'(result.event_kind), 4'(want.event_kind));
                    check_field("button_code", 4'(result.button_code), 4'(want.button_code));
                    check_field("sample_invalid", 4'(result.sample_invalid),
                        4'(want.sample_invalid));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_sample(logic ch, int v);
        lbdd_pkg::sample_item_t s;
        s.channel = ch;
        s.adc_sample = lbdd_pkg::SAMPLE_BITS'(v);
        adc_samples_q.push_back(s);
    endtask

    // random reading inside one band, often right on an edge
    function automatic int band_value(logic ch, int band);
        int lo;
        int hi;
        lo = (band == 0) ? 0 : band_top(ch, band - 1) + 1;
        hi = band_top(ch, band);
        case ($urandom_range(7))
            0: return lo;
            1: return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // mostly held presses of random length around the settle count, some noise
    task automatic queue_random(int n);
        int  added;
        int  len;
        int  band;
        int  load;
        logic ch;
        added = 0;
        load = (settle_cfg == '0) ? 1 : int'(settle_cfg);
        while (added < n)
        begin
            ch = 1'($urandom_range(1));
            if ($urandom_range(99) < 15)
            begin
                push_sample(ch, $urandom_range(1023));
                added++;
            end
            else
            begin
                band = $urandom_range(band_count(ch) - 1);
                len = $urandom_range(load + 3, 1);
                for (int i = 0; i < len; i++)
                begin
                    push_sample(ch, band_value(ch, band));
                    // other ladder interleaved mid-press
                    if ($urandom_range(99) < 20)
                    begin
                        push_sample(~ch, $urandom_range(1023));
                        added++;
                    end
                end
                added += len;
            end
        end
    endtask

    // sender holds off until every predicted result has been taken
    task automatic wait_idle();
        while (adc_samples_q.size() != 0 || sample_valid || predicted_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_settle(logic [lbdd_pkg::SETTLE_BITS-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        settle_cfg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_idle_mode(int mode);
        sender_idle_pct = SENDER_IDLE_PCT[mode];
        receiver_stall_pct = RECEIVER_STALL_PCT[mode];
    endtask

    initial
    begin
        logic [lbdd_pkg::SETTLE_BITS-1:0] settings [5];
        settings = '{4'd0, 4'd15, lbdd_pkg::SETTLE_BITS'($urandom_range(14, 2)), 4'd1,
            lbdd_pkg::SETTLE_BITS'($urandom_range(15, 1))};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle_mode(0);
        for (int i = 0; i < DIRECTED_ITEMS; i++)
            push_sample(DIRECTED_CH[i], DIRECTED_VALUE[i]);
        wait_idle();

        for (int p = 0; p < 5; p++)
        begin
            write_settle(settings[p]);
            set_idle_mode((p + 1) % MODE_COUNT);
            queue_random(BATCH_ITEMS);
            wait_idle();
            set_idle_mode((p + 3) % MODE_COUNT);
            queue_random(BATCH_ITEMS);
            wait_idle();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
